// File: rtl/mcu_alu_add_inc_jump_unit_assert.svh
// Assertion helpers for the top RTL file of the ALU unit.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef MCU_ALU_ADD_INC_JUMP_UNIT_ASSERT_SVH
`define MCU_ALU_ADD_INC_JUMP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAIJ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MAIJ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/maij_pkg.sv
package maij_pkg;

    // Register file geometry: two banks of byte registers, even and odd indexes.
    localparam int REGISTER_COUNT = 32;
    localparam int IDX_W          = $clog2(REGISTER_COUNT);
    localparam int ROW_COUNT      = REGISTER_COUNT / 2;
    localparam int ROW_W          = $clog2(ROW_COUNT);
    localparam int PAIR_BASE      = 24;
    localparam logic [ROW_W-1:0] PAIR_ROW = ROW_W'(PAIR_BASE / 2);

    localparam int PC_W  = 17;
    localparam int OFF_W = 12;

    // Status register bit positions.
    localparam int F_C = 0;
    localparam int F_Z = 1;
    localparam int F_N = 2;
    localparam int F_V = 3;
    localparam int F_S = 4;
    localparam int F_H = 5;

    typedef enum logic [2:0] {
        OP_INC  = 3'd0,
        OP_ADD  = 3'd1,
        OP_ADC  = 3'd2,
        OP_ADIW = 3'd3,
        OP_RJMP = 3'd4
    } t_op;

    // One write request into a register bank.
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [7:0]       data;
    } t_bank_wr;

    // Result of one instruction.
    typedef struct packed {
        logic [15:0]     value;
        logic [7:0]      sreg;
        logic [PC_W-1:0] pc;
    } t_alu_res;

    // N, V, Z and S flags placed at their status register positions.
    function automatic logic [7:0] nzs(input logic n, input logic v, input logic z);
        logic [7:0] f;
        f      = 8'h00;
        f[F_N] = n;
        f[F_V] = v;
        f[F_Z] = z;
        f[F_S] = n ^ v;
        return f;
    endfunction

endpackage

// File: rtl/mcu_alu_add_inc_jump_unit.sv
// An accepted word is registered in the execute stage, its result word in
// the output register. One instruction per cycle unless the result side
// stalls; registered register-file reads are forwarded from the write of
// the instruction ahead, so no bubble occurs. The output register lets the
// next word be taken while a result waits. Reset (synchronous, active low)
// zeroes flags and PC; registers at once by valid bits, no clearing pass.
module mcu_alu_add_inc_jump_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_req_type,
    input  logic [4:0]                 i_dest_index,
    input  logic [4:0]                 i_source_index,
    input  logic [1:0]                 i_pair_select,
    input  logic [5:0]                 i_word_immediate,
    input  logic signed [11:0]         i_jump_offset,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [15:0]                o_written_value,
    output logic [7:0]                 o_status_flags,
    output logic [16:0]                o_program_count
);
    import maij_pkg::*;

    `include "mcu_alu_add_inc_jump_unit_assert.svh"

    // Execute stage registers.
    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [IDX_W-1:0] r_s1_dest;
    logic             r_s1_a_bank;
    logic             r_s1_b_bank;
    logic [1:0]       r_s1_pair;
    logic [5:0]       r_s1_imm;
    logic [OFF_W-1:0] r_s1_off;

    // Architectural state kept in flops.
    logic [7:0]       r_sreg;
    logic [PC_W-1:0]  r_pc;

    // Output register.
    logic             r_out_valid;
    logic             n_out_valid;
    logic [15:0]      r_out_value;
    logic [7:0]       r_out_sreg;
    logic [PC_W-1:0]  r_out_pc;

    logic             in_accept;
    logic             s1_fire;
    t_op              in_op;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic [7:0]       even_rd_a;
    logic [7:0]       even_rd_b;
    logic [7:0]       odd_rd_a;
    logic [7:0]       odd_rd_b;
    logic [7:0]       opa;
    logic [7:0]       opb;
    logic             byte_write;
    logic [ROW_W-1:0] pair_row;
    t_bank_wr         wr_even;
    t_bank_wr         wr_odd;
    t_alu_res         alu_res;

    // Handshake: the execute stage moves when the output register is free or its word is taken.
    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_op      = t_op'(i_req_type);

    // Read addresses: ADIW reads its pair, other operations dest and source.
    always_comb begin
        if (in_op == OP_ADIW) begin
            rd_addr_a = {PAIR_ROW + ROW_W'(i_pair_select), 1'b0};
            rd_addr_b = {PAIR_ROW + ROW_W'(i_pair_select), 1'b1};
        end else begin
            rd_addr_a = i_dest_index;
            rd_addr_b = i_source_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op     <= in_op;
            r_s1_dest   <= i_dest_index;
            r_s1_a_bank <= rd_addr_a[0];
            r_s1_b_bank <= rd_addr_b[0];
            r_s1_pair   <= i_pair_select;
            r_s1_imm    <= i_word_immediate;
            r_s1_off    <= i_jump_offset;
        end
    end

    // Register file banks: even indexes in one, odd indexes in the other.
    maij_bank_ram u_even_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr_even),
        .i_rd_en    (in_accept),
        .i_rd_row_a (rd_addr_a[IDX_W-1:1]),
        .i_rd_row_b (rd_addr_b[IDX_W-1:1]),
        .o_rd_a     (even_rd_a),
        .o_rd_b     (even_rd_b)
    );

    maij_bank_ram u_odd_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr_odd),
        .i_rd_en    (in_accept),
        .i_rd_row_a (rd_addr_a[IDX_W-1:1]),
        .i_rd_row_b (rd_addr_b[IDX_W-1:1]),
        .o_rd_a     (odd_rd_a),
        .o_rd_b     (odd_rd_b)
    );

    assign opa = r_s1_a_bank ? odd_rd_a : even_rd_a;
    assign opb = r_s1_b_bank ? odd_rd_b : even_rd_b;

    maij_alu u_alu (
        .i_op   (r_s1_op),
        .i_opa  (opa),
        .i_opb  (opb),
        .i_imm  (r_s1_imm),
        .i_off  (r_s1_off),
        .i_sreg (r_sreg),
        .i_pc   (r_pc),
        .o_res  (alu_res)
    );

    // Write back: byte ops hit one bank, ADIW writes both halves of its pair.
    always_comb begin
        byte_write   = (r_s1_op == OP_INC) || (r_s1_op == OP_ADD) || (r_s1_op == OP_ADC);
        pair_row     = PAIR_ROW + ROW_W'(r_s1_pair);
        wr_even.en   = s1_fire && ((byte_write && !r_s1_dest[0]) || (r_s1_op == OP_ADIW));
        wr_odd.en    = s1_fire && ((byte_write && r_s1_dest[0]) || (r_s1_op == OP_ADIW));
        wr_even.row  = (r_s1_op == OP_ADIW) ? pair_row : r_s1_dest[IDX_W-1:1];
        wr_odd.row   = (r_s1_op == OP_ADIW) ? pair_row : r_s1_dest[IDX_W-1:1];
        wr_even.data = alu_res.value[7:0];
        wr_odd.data  = (r_s1_op == OP_ADIW) ? alu_res.value[15:8] : alu_res.value[7:0];
    end

    // Status register and program counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sreg <= 8'h00;
            r_pc   <= '0;
        end else if (s1_fire) begin
            r_sreg <= alu_res.sreg;
            r_pc   <= alu_res.pc;
        end
    end

    // Output register holds a result word until it is taken.
    always_comb begin
        if (s1_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_value <= alu_res.value;
            r_out_sreg  <= alu_res.sreg;
            r_out_pc    <= alu_res.pc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_written_value = r_out_value;
    assign o_status_flags  = r_out_sreg;
    assign o_program_count = r_out_pc;

    // The program counter moves only after a jump has executed.
    `MAIJ_ASSERT_SAME(a_pc_only_jump, !$stable(r_pc), $past(s1_fire && r_s1_op == OP_RJMP))
    // ADIW writes both banks at the same pair row.
    `MAIJ_ASSERT_SAME(a_adiw_pair, s1_fire && r_s1_op == OP_ADIW,
                      wr_even.en && wr_odd.en && wr_even.row == wr_odd.row)
    // An accepted word always lands in the execute stage.
    `MAIJ_ASSERT_NEXT(a_accept_fills, in_accept, r_s1_valid)
    // The two upper status bits are never touched.
    `MAIJ_ASSERT_NEXT(a_sreg_top, 1'b1, $stable(r_sreg[7:6]))

endmodule

// File: rtl/maij_bank_ram.sv
module maij_bank_ram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  maij_pkg::t_bank_wr         i_wr,
    input  logic                       i_rd_en,
    input  logic [maij_pkg::ROW_W-1:0] i_rd_row_a,
    input  logic [maij_pkg::ROW_W-1:0] i_rd_row_b,
    output logic [7:0]                 o_rd_a,
    output logic [7:0]                 o_rd_b
);
    import maij_pkg::*;

    logic [7:0]           r_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] r_valid;

    // Storage array, no reset; unwritten rows are masked by the valid bits.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.row] <= i_wr.data;
        end
    end

    // Valid bits make every row read as zero after reset until it is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.row] <= 1'b1;
        end
    end

    // Registered reads; a write to the same row in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && i_wr.row == i_rd_row_a) begin
                o_rd_a <= i_wr.data;
            end else begin
                o_rd_a <= r_valid[i_rd_row_a] ? r_mem[i_rd_row_a] : 8'h00;
            end
            if (i_wr.en && i_wr.row == i_rd_row_b) begin
                o_rd_b <= i_wr.data;
            end else begin
                o_rd_b <= r_valid[i_rd_row_b] ? r_mem[i_rd_row_b] : 8'h00;
            end
        end
    end

endmodule

// File: rtl/maij_alu.sv
module maij_alu (
    input  maij_pkg::t_op              i_op,
    input  logic [7:0]                 i_opa,
    input  logic [7:0]                 i_opb,
    input  logic [5:0]                 i_imm,
    input  logic [maij_pkg::OFF_W-1:0] i_off,
    input  logic [7:0]                 i_sreg,
    input  logic [maij_pkg::PC_W-1:0]  i_pc,
    output maij_pkg::t_alu_res         o_res
);
    import maij_pkg::*;

    logic [8:0]  sum9;
    logic [7:0]  r8;
    logic [15:0] old16;
    logic [15:0] r16;
    logic        cin;
    logic        h;
    logic        c;
    logic        v;
    logic [7:0]  flags;
    logic [7:0]  mask;

    // Datapath results for all operations; the case below picks one.
    always_comb begin
        cin   = (i_op == OP_ADC) ? i_sreg[F_C] : 1'b0;
        sum9  = {1'b0, i_opa} + {1'b0, i_opb} + {8'b0, cin};
        r8    = sum9[7:0];
        old16 = {i_opb, i_opa};
        r16   = old16 + {10'b0, i_imm};
        h = (i_opa[3] & i_opb[3]) | (i_opb[3] & ~r8[3]) | (~r8[3] & i_opa[3]);
        c = (i_opa[7] & i_opb[7]) | (i_opb[7] & ~r8[7]) | (~r8[7] & i_opa[7]);
        v = (i_opa[7] & i_opb[7] & ~r8[7]) | (~i_opa[7] & ~i_opb[7] & r8[7]);
    end

    // Select the written value and the flags that the operation updates.
    always_comb begin
        o_res.value = 16'h0000;
        o_res.pc    = i_pc;
        flags       = 8'h00;
        mask        = 8'h00;
        case (i_op)
            OP_INC: begin
                o_res.value = {8'h00, i_opa + 8'd1};
                flags = nzs(o_res.value[7], o_res.value[7:0] == 8'h80,
                            o_res.value[7:0] == 8'h00);
                mask  = 8'h00;
                mask[F_Z] = 1'b1;
                mask[F_N] = 1'b1;
                mask[F_V] = 1'b1;
                mask[F_S] = 1'b1;
            end
            OP_ADD, OP_ADC: begin
                o_res.value = {8'h00, r8};
                flags       = nzs(r8[7], v, r8 == 8'h00);
                flags[F_H]  = h;
                flags[F_C]  = c;
                mask        = 8'h3F;
            end
            OP_ADIW: begin
                o_res.value = r16;
                flags = nzs(r16[15], ~old16[15] & r16[15], r16 == 16'h0000);
                flags[F_C] = ~r16[15] & old16[15];
                mask  = 8'h00;
                mask[F_C] = 1'b1;
                mask[F_Z] = 1'b1;
                mask[F_N] = 1'b1;
                mask[F_V] = 1'b1;
                mask[F_S] = 1'b1;
            end
            OP_RJMP: begin
                o_res.pc = i_pc + {{(PC_W-OFF_W){i_off[OFF_W-1]}}, i_off};
            end
            default: begin
                o_res.value = 16'h0000;
            end
        endcase
        o_res.sreg = (i_sreg & ~mask) | (flags & mask);
    end

endmodule

// File: dv/alu_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the ALU unit, predicts every result word from the
// accepted instruction words and compares the two, field by field.
module alu_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [4:0]  i_dest_index,
    input  logic [4:0]  i_source_index,
    input  logic [1:0]  i_pair_select,
    input  logic [5:0]  i_word_immediate,
    input  logic [11:0] i_jump_offset,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_written_value,
    input  logic [7:0]  i_status_flags,
    input  logic [16:0] i_program_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_checked
);
    import maij_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the architectural state.
    logic [7:0]      shadow_gpr [REGISTER_COUNT];
    logic [7:0]      shadow_sreg;
    logic [PC_W-1:0] shadow_pc;

    t_alu_res predicted_words [$];

    // Executes one instruction on the shadow state and returns its result word.
    function automatic t_alu_res execute_word(
        input logic [2:0]  op,
        input logic [4:0]  d,
        input logic [4:0]  s,
        input logic [1:0]  p,
        input logic [5:0]  k,
        input logic [11:0] off
    );
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r;
        logic [15:0] w_old;
        logic [15:0] w_new;
        logic [4:0]  lo_i;
        logic [4:0]  hi_i;
        logic        cin;
        logic        ovf;
        t_alu_res    res;
        res.value = 16'h0000;
        case (op)
            OP_INC: begin
                r = shadow_gpr[d] + 8'd1;
                shadow_gpr[d] = r;
                ovf = (r == 8'h80);
                shadow_sreg[F_N] = r[7];
                shadow_sreg[F_V] = ovf;
                shadow_sreg[F_Z] = (r == 8'h00);
                shadow_sreg[F_S] = r[7] ^ ovf;
                res.value = {8'h00, r};
            end
            OP_ADD, OP_ADC: begin
                // Both operands are read before the write, so d == s doubles.
                a = shadow_gpr[d];
                b = shadow_gpr[s];
                cin = (op == OP_ADC) ? shadow_sreg[F_C] : 1'b0;
                r = a + b + {7'd0, cin};
                ovf = (a[7] & b[7] & ~r[7]) | (~a[7] & ~b[7] & r[7]);
                shadow_sreg[F_H] = (a[3] & b[3]) | (b[3] & ~r[3]) | (~r[3] & a[3]);
                shadow_sreg[F_C] = (a[7] & b[7]) | (b[7] & ~r[7]) | (~r[7] & a[7]);
                shadow_sreg[F_N] = r[7];
                shadow_sreg[F_V] = ovf;
                shadow_sreg[F_Z] = (r == 8'h00);
                shadow_sreg[F_S] = r[7] ^ ovf;
                shadow_gpr[d] = r;
                res.value = {8'h00, r};
            end
            OP_ADIW: begin
                lo_i = 5'(PAIR_BASE) + {2'b00, p, 1'b0};
                hi_i = lo_i + 5'd1;
                w_old = {shadow_gpr[hi_i], shadow_gpr[lo_i]};
                w_new = w_old + {10'd0, k};
                ovf = ~w_old[15] & w_new[15];
                shadow_sreg[F_C] = ~w_new[15] & w_old[15];
                shadow_sreg[F_N] = w_new[15];
                shadow_sreg[F_V] = ovf;
                shadow_sreg[F_Z] = (w_new == 16'h0000);
                shadow_sreg[F_S] = w_new[15] ^ ovf;
                shadow_gpr[lo_i] = w_new[7:0];
                shadow_gpr[hi_i] = w_new[15:8];
                res.value = w_new;
            end
            OP_RJMP: begin
                shadow_pc = shadow_pc + {{(PC_W-OFF_W){off[OFF_W-1]}}, off};
            end
            default: begin
                // Spare operation codes leave all state alone.
            end
        endcase
        res.sreg = shadow_sreg;
        res.pc   = shadow_pc;
        return res;
    endfunction

    // Check the result word first, then queue the prediction for a new word.
    always @(posedge i_clk) begin
        t_alu_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                shadow_gpr[i] = 8'h00;
            end
            shadow_sreg = 8'h00;
            shadow_pc   = '0;
            predicted_words.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result word: value %h flags %h pc %h",
                                 $realtime, i_written_value, i_status_flags, i_program_count);
                    end
                end else begin
                    want = predicted_words.pop_front();
                    o_words_checked++;
                    if (i_written_value !== want.value || i_status_flags !== want.sreg ||
                        i_program_count !== want.pc) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch on word %0d: expected value %h flags %h pc %h",
                                     $realtime, o_words_checked, want.value, want.sreg, want.pc);
                            $display("%0t:                     got value %h flags %h pc %h",
                                     $realtime, i_written_value, i_status_flags, i_program_count);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_words.push_back(execute_word(i_req_type, i_dest_index,
                    i_source_index, i_pair_select, i_word_immediate, i_jump_offset));
            end
            o_pending = predicted_words.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import maij_pkg::*;

    localparam int RANDOM_WORDS = 1800;
    localparam int IDLE_LIMIT   = 500;
    localparam int DRAIN_CYCLES = 8;

    // Operation codes the decoder does not use.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [4:0]  i_dest_index;
    logic [4:0]  i_source_index;
    logic [1:0]  i_pair_select;
    logic [5:0]  i_word_immediate;
    logic [11:0] i_jump_offset;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_written_value;
    logic [7:0]  o_status_flags;
    logic [16:0] o_program_count;

    int fail_count;
    int pending;
    int words_checked;
    int op_tally [8];
    int idle_cycles;
    bit calm_in;
    bit calm_out;

    mcu_alu_add_inc_jump_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_dest_index     (i_dest_index),
        .i_source_index   (i_source_index),
        .i_pair_select    (i_pair_select),
        .i_word_immediate (i_word_immediate),
        .i_jump_offset    (i_jump_offset),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_written_value  (o_written_value),
        .o_status_flags   (o_status_flags),
        .o_program_count  (o_program_count)
    );

    alu_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_dest_index     (i_dest_index),
        .i_source_index   (i_source_index),
        .i_pair_select    (i_pair_select),
        .i_word_immediate (i_word_immediate),
        .i_jump_offset    (i_jump_offset),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_written_value  (o_written_value),
        .i_status_flags   (o_status_flags),
        .i_program_count  (o_program_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_words_checked  (words_checked)
    );

    // Clock with an 8 ns period.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Presents one instruction word after a random gap (none while calm_in is set) and holds it until taken.
    task automatic send_word(
        input logic [2:0]  op,
        input logic [4:0]  d,
        input logic [4:0]  s,
        input logic [1:0]  p,
        input logic [5:0]  k,
        input logic [11:0] off
    );
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= op;
        i_dest_index     <= d;
        i_source_index   <= s;
        i_pair_select    <= p;
        i_word_immediate <= k;
        i_jump_offset    <= off;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        op_tally[op]++;
    endtask

    // Builds one random instruction word, mostly valid operations.
    task automatic send_random_word();
        logic [2:0]  op;
        logic [4:0]  d;
        logic [4:0]  s;
        logic [5:0]  k;
        logic [11:0] off;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)      op = OP_INC;
        else if (pick < 40) op = OP_ADD;
        else if (pick < 62) op = OP_ADC;
        else if (pick < 82) op = OP_ADIW;
        else if (pick < 94) op = OP_RJMP;
        else                op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        // Lean on the pair registers so ADIW sees values built by byte ops.
        d = ($urandom_range(0, 9) < 3) ? 5'($urandom_range(24, 31)) : 5'($urandom);
        s = ($urandom_range(0, 9) == 0) ? d : 5'($urandom);
        case ($urandom_range(0, 9))
            0:       k = 6'd0;
            1:       k = 6'd63;
            default: k = 6'($urandom);
        endcase
        case ($urandom_range(0, 19))
            0:       off = 12'h800;
            1:       off = 12'h7FF;
            2:       off = 12'hFFF;
            default: off = 12'($urandom);
        endcase
        send_word(op, d, s, 2'($urandom), k, off);
    endtask

    // Main stimulus: reset, directed words, then random words.
    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_req_type       <= '0;
        i_dest_index     <= '0;
        i_source_index   <= '0;
        i_pair_select    <= '0;
        i_word_immediate <= '0;
        i_jump_offset    <= '0;
        calm_in  = 1'b0;
        calm_out = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Build 0x7F then step into signed overflow and carry out.
        send_word(OP_INC,  5'd0,  5'd0,  2'd0, 6'd0,  12'h000);
        send_word(OP_ADIW, 5'd0,  5'd0,  2'd0, 6'd63, 12'h000);
        send_word(OP_ADD,  5'd24, 5'd24, 2'd0, 6'd0,  12'h000);
        send_word(OP_INC,  5'd24, 5'd0,  2'd0, 6'd0,  12'h000);
        send_word(OP_INC,  5'd24, 5'd0,  2'd0, 6'd0,  12'h000);
        send_word(OP_ADD,  5'd24, 5'd24, 2'd0, 6'd0,  12'h000);
        send_word(OP_ADC,  5'd24, 5'd0,  2'd0, 6'd0,  12'h000);
        // Zero word, then a word of 0xFFFF so ADIW wraps and sets carry.
        send_word(OP_ADIW, 5'd0,  5'd0,  2'd3, 6'd0,  12'h000);
        send_word(OP_ADIW, 5'd0,  5'd0,  2'd3, 6'd63, 12'h000);
        send_word(OP_ADD,  5'd30, 5'd30, 2'd0, 6'd0,  12'h000);
        send_word(OP_ADD,  5'd30, 5'd30, 2'd0, 6'd0,  12'h000);
        send_word(OP_INC,  5'd30, 5'd0,  2'd0, 6'd0,  12'h000);
        send_word(OP_INC,  5'd30, 5'd0,  2'd0, 6'd0,  12'h000);
        send_word(OP_INC,  5'd30, 5'd0,  2'd0, 6'd0,  12'h000);
        send_word(OP_ADD,  5'd31, 5'd30, 2'd0, 6'd0,  12'h000);
        send_word(OP_ADIW, 5'd0,  5'd0,  2'd3, 6'd63, 12'h000);
        send_word(OP_ADIW, 5'd0,  5'd0,  2'd1, 6'd63, 12'h000);
        send_word(OP_ADIW, 5'd0,  5'd0,  2'd2, 6'd1,  12'h000);
        // Jumps at both offset extremes, with a wrap below zero.
        send_word(OP_RJMP, 5'd0,  5'd0,  2'd0, 6'd0,  12'h800);
        send_word(OP_RJMP, 5'd0,  5'd0,  2'd0, 6'd0,  12'h7FF);
        send_word(OP_RJMP, 5'd31, 5'd31, 2'd3, 6'd63, 12'h000);
        // Spare codes must change nothing.
        send_word(OP_SPARE_5, 5'd31, 5'd31, 2'd3, 6'd63, 12'hFFF);
        send_word(OP_SPARE_6, 5'd31, 5'd31, 2'd3, 6'd63, 12'hFFF);
        send_word(OP_SPARE_7, 5'd31, 5'd31, 2'd3, 6'd63, 12'hFFF);
        send_word(OP_INC,  5'd31, 5'd0,  2'd0, 6'd0,  12'h000);

        // Random words, with stretches where either side never idles.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 150 == 0) begin
                calm_in  = ($urandom_range(0, 3) == 0);
                calm_out = ($urandom_range(0, 3) == 0);
            end
            send_random_word();
        end
        i_in_valid <= 1'b0;

        // Drain the outstanding results.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: sent INC %0d, ADD %0d, ADC %0d, ADIW %0d, RJMP %0d, spare codes %0d",
                 op_tally[OP_INC], op_tally[OP_ADD], op_tally[OP_ADC], op_tally[OP_ADIW],
                 op_tally[OP_RJMP],
                 op_tally[OP_SPARE_5] + op_tally[OP_SPARE_6] + op_tally[OP_SPARE_7]);
        $display("Summary: %0d result words compared, %0d failures, %0d still expected",
                 words_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: random stall before each result word.
    initial begin
        int hold;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = calm_out ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+rtl
rtl/maij_pkg.sv
rtl/maij_bank_ram.sv
rtl/maij_alu.sv
rtl/mcu_alu_add_inc_jump_unit.sv
dv/alu_result_checker.sv
dv/tb.sv
